@@ design/bspline_curve_evaluate_defines.svh @@
// Assertion macros shared by the checker of the spline evaluator.
`ifndef BSPLINE_CURVE_EVALUATE_DEFINES_SVH
`define BSPLINE_CURVE_EVALUATE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define BCE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bce check failed");

// Next-cycle implication, sampled on clk and off while rst is high.
`define BCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bce check failed");

`endif

@@ design/bce_pkg.sv @@
// Types, codes and helpers shared by the spline evaluator modules.
package bce_pkg;

  localparam logic [1:0] ACT_LOAD_KNOT = 2'd0;
  localparam logic [1:0] ACT_LOAD_COEF = 2'd1;
  localparam logic [1:0] ACT_EVAL      = 2'd2;

  localparam logic [1:0] REG_KNOTS_IN_USE   = 2'd0;
  localparam logic [1:0] REG_CLAMP_NEGATIVE = 2'd1;

  localparam logic [5:0] KNOTS_RESET = 6'd8;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         slot;
    logic [31:0]        knot_value;
    logic signed [31:0] coefficient;
    logic [31:0]        sample_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic               outside_support;
  } out_item_t;

  typedef struct packed {
    logic               go;
    logic signed [32:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'(S32_MAX)) r = S32_MAX;
    else if (v < 40'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ design/bce_divider.sv @@
// Iterative Q1.30 ratio unit: trunc(num * 2^30 / den), saturated, one bit per cycle.
module bce_divider import bce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        active;
  logic [4:0]  count;
  logic [31:0] rem;
  logic [29:0] qacc;
  logic        first_bit;
  logic        neg;
  logic [31:0] ad;

  logic [31:0] an_in;
  logic [31:0] ad_in;
  logic [32:0] sh;
  logic        qbit;
  logic [31:0] rem_next;
  logic [30:0] mag;

  assign an_in = req.num[32] ? 32'(-req.num) : req.num[31:0];
  assign ad_in = req.den[32] ? 32'(-req.den) : req.den[31:0];

  always_comb begin
    sh = {rem, (count == 5'd0) ? first_bit : 1'b0};
    qbit = (sh >= {1'b0, ad});
    rem_next = qbit ? 32'(sh - {1'b0, ad}) : sh[31:0];
    mag = {qacc, qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        neg <= req.num[32] ^ req.den[32];
        ad  <= ad_in;
        if (req.den == '0) begin
          rsp.quot <= '0;
          rsp.done <= 1'b1;
        end else if ({1'b0, an_in} >= {ad_in, 1'b0}) begin
          // A quotient of 2^31 or more always saturates.
          rsp.quot <= (req.num[32] ^ req.den[32]) ? S32_MIN : S32_MAX;
          rsp.done <= 1'b1;
        end else begin
          rem       <= {1'b0, an_in[31:1]};
          first_bit <= an_in[0];
          qacc      <= '0;
          count     <= '0;
          active    <= 1'b1;
        end
      end else if (active) begin
        rem   <= rem_next;
        qacc  <= mag[29:0];
        count <= count + 5'd1;
        if (count == 5'd30) begin
          active   <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quot <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
      end
    end
  end

endmodule

@@ design/bce_product.sv @@
// Two-stage Q1.30 product: full multiply, then truncation toward zero by 2^30.
module bce_product import bce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               valid,
  output logic signed [33:0] prod
);

  logic               stage1_valid;
  logic signed [63:0] full;
  logic signed [63:0] biased;

  assign biased = full + (full[63] ? 64'sd1073741823 : 64'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      valid        <= 1'b0;
    end else begin
      stage1_valid <= go;
      valid        <= stage1_valid;
    end
    full <= a * b;
    prod <= biased[63:30];
  end

endmodule

@@ design/bspline_curve_evaluate.sv @@
// Top level of the spline evaluator: knot, coefficient and basis memories and the sequencer.
//
//  channel   | signals                                  | transfer
//  ----------+------------------------------------------+---------------------------
//  request   | start, busy, request (in_item_t)         | start && !busy
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//  result    | result_strobe, result (out_item_t)       | strobe, one cycle
//
// Loads and ignored actions never raise busy.
// An evaluation steps through the knot reads, the degree-zero basis, DEGREE levels of
// basis terms and the weighted sum; each nonzero lower basis value waits on the
// bit-serial divider, and the knot memory has a single read port.
// Reset is synchronous and clears only control state and the registers.
// The receiver cannot stall; config is always ready.
module bspline_curve_evaluate import bce_pkg::*; #(
  parameter int MAX_KNOTS = 32,
  parameter int DEGREE    = 3
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output logic      result_strobe,
  output out_item_t result
);

  localparam int CD  = MAX_KNOTS - 1 - DEGREE;
  localparam int KI  = $clog2(MAX_KNOTS);
  localparam int NW  = $clog2(MAX_KNOTS + 1);
  localparam int CIW = (CD > 1) ? $clog2(CD) : 1;
  localparam int PW  = $clog2(DEGREE + 1);

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_RD_FIRST = 22'h000002,
    ST_RD_LAST  = 22'h000004,
    ST_CHK      = 22'h000008,
    ST_L0_A     = 22'h000010,
    ST_L0_B     = 22'h000020,
    ST_L0_W     = 22'h000040,
    ST_LV_R0    = 22'h000080,
    ST_LV_R1    = 22'h000100,
    ST_LV_R2    = 22'h000200,
    ST_LV_R3    = 22'h000400,
    ST_LV_F1    = 22'h000800,
    ST_LV_D1    = 22'h001000,
    ST_LV_M1    = 22'h002000,
    ST_LV_F2    = 22'h004000,
    ST_LV_D2    = 22'h008000,
    ST_LV_M2    = 22'h010000,
    ST_LV_W     = 22'h020000,
    ST_SUM_R    = 22'h040000,
    ST_SUM_M    = 22'h080000,
    ST_SUM_W    = 22'h100000,
    ST_FINISH   = 22'h200000
  } state_t;

  state_t state;

  logic [5:0] knots_in_use;
  logic       clamp_negative;

  logic [31:0]        knot_mem  [MAX_KNOTS];
  logic signed [31:0] coef_mem  [CD];
  logic signed [31:0] basis_mem [MAX_KNOTS];
  logic [31:0]        knot_q;
  logic signed [31:0] coef_q;
  logic signed [31:0] basis_q;

  logic [KI-1:0]      knot_raddr;
  logic [KI-1:0]      basis_raddr;
  logic               basis_we;
  logic signed [31:0] basis_wdata;

  logic [KI-1:0] idx;
  logic [PW-1:0] lvl;
  logic [31:0]   x;
  logic [31:0]   ka, kb, kc, kd;
  logic signed [31:0] ba, bb;
  logic signed [33:0] t1, t2;
  logic signed [39:0] acc;
  logic               outside;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic               mul_go;
  logic signed [31:0] mul_a, mul_b;
  logic               mul_valid;
  logic signed [33:0] mul_prod;

  logic [NW-1:0] n_eff;
  logic          has_basis;
  logic [NW:0]   idx_w;
  logic          l0_last, lv_last, sum_last;
  logic [6:0]    slot_w;
  logic          accept;
  logic signed [31:0] acc_sat;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign slot_w    = {2'b00, request.slot};

  assign n_eff = ({1'b0, knots_in_use} > 7'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : NW'(knots_in_use);
  assign has_basis = (NW'(n_eff) > NW'(DEGREE + 1));
  assign idx_w     = (NW + 1)'(idx);
  assign l0_last   = (idx_w == ((NW + 1)'(n_eff) - (NW + 1)'(2)));
  assign lv_last   = (idx_w == ((NW + 1)'(n_eff) - (NW + 1)'(2) - (NW + 1)'(lvl)));
  assign sum_last  = (idx_w == ((NW + 1)'(n_eff) - (NW + 1)'(DEGREE + 2)));
  assign acc_sat   = sat32(acc);

  bce_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bce_product u_mul (
    .clk   (clk),
    .rst   (rst),
    .go    (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .valid (mul_valid),
    .prod  (mul_prod)
  );

  // Memory ports.
  always_ff @(posedge clk) begin
    if (accept && request.action == ACT_LOAD_KNOT && slot_w < 7'(MAX_KNOTS)) begin
      knot_mem[slot_w[KI-1:0]] <= request.knot_value;
    end
    knot_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && request.action == ACT_LOAD_COEF && slot_w < 7'(CD)) begin
      coef_mem[slot_w[CIW-1:0]] <= request.coefficient;
    end
    coef_q <= coef_mem[idx[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (basis_we) begin
      basis_mem[idx] <= basis_wdata;
    end
    basis_q <= basis_mem[basis_raddr];
  end

  always_comb begin
    knot_raddr  = idx;
    basis_raddr = idx;
    basis_we    = 1'b0;
    basis_wdata = '0;
    div_req     = '0;
    mul_go      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      ST_RD_FIRST: knot_raddr = '0;
      ST_RD_LAST:  knot_raddr = KI'(n_eff - NW'(1));
      ST_L0_B:     knot_raddr = idx + KI'(1);
      ST_L0_W: begin
        basis_we    = 1'b1;
        basis_wdata = (x >= ka && x < knot_q) ? Q30_ONE : '0;
      end
      ST_LV_R1: begin
        knot_raddr  = idx + KI'(1);
        basis_raddr = idx + KI'(1);
      end
      ST_LV_R2:    knot_raddr = idx + KI'(lvl);
      ST_LV_R3:    knot_raddr = idx + KI'(lvl) + KI'(1);
      ST_LV_F1: begin
        div_req.go  = (ba != '0);
        div_req.num = $signed({1'b0, x}) - $signed({1'b0, ka});
        div_req.den = $signed({1'b0, kc}) - $signed({1'b0, ka});
      end
      ST_LV_D1: begin
        mul_go = div_rsp.done;
        mul_a  = div_rsp.quot;
        mul_b  = ba;
      end
      ST_LV_F2: begin
        div_req.go  = (bb != '0);
        div_req.num = $signed({1'b0, kd}) - $signed({1'b0, x});
        div_req.den = $signed({1'b0, kd}) - $signed({1'b0, kb});
      end
      ST_LV_D2: begin
        mul_go = div_rsp.done;
        mul_a  = div_rsp.quot;
        mul_b  = bb;
      end
      ST_LV_W: begin
        basis_we    = 1'b1;
        basis_wdata = sat32(40'(t1) + 40'(t2));
      end
      ST_SUM_M: begin
        mul_go = 1'b1;
        mul_a  = coef_q;
        mul_b  = basis_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_strobe  <= 1'b0;
      knots_in_use   <= KNOTS_RESET;
      clamp_negative <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KNOTS_IN_USE:   knots_in_use   <= cfg_data;
          REG_CLAMP_NEGATIVE: clamp_negative <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && request.action == ACT_EVAL) begin
            x     <= request.sample_x;
            state <= ST_RD_FIRST;
          end
        end
        ST_RD_FIRST: state <= ST_RD_LAST;
        ST_RD_LAST: begin
          ka    <= knot_q;
          state <= ST_CHK;
        end
        ST_CHK: begin
          outside <= (n_eff < NW'(2)) || (x < ka) || (x >= knot_q);
          acc     <= '0;
          idx     <= '0;
          state   <= has_basis ? ST_L0_A : ST_FINISH;
        end
        ST_L0_A: state <= ST_L0_B;
        ST_L0_B: begin
          ka    <= knot_q;
          state <= ST_L0_W;
        end
        ST_L0_W: begin
          if (l0_last) begin
            idx   <= '0;
            lvl   <= PW'(1);
            state <= ST_LV_R0;
          end else begin
            idx   <= idx + KI'(1);
            state <= ST_L0_A;
          end
        end
        ST_LV_R0: state <= ST_LV_R1;
        ST_LV_R1: begin
          ka    <= knot_q;
          ba    <= basis_q;
          state <= ST_LV_R2;
        end
        ST_LV_R2: begin
          kb    <= knot_q;
          bb    <= basis_q;
          state <= ST_LV_R3;
        end
        ST_LV_R3: begin
          kc    <= knot_q;
          state <= ST_LV_F1;
        end
        ST_LV_F1: begin
          kd <= knot_q;
          // A zero lower-order basis value makes the whole term zero.
          if (ba != '0) begin
            state <= ST_LV_D1;
          end else begin
            t1    <= '0;
            state <= ST_LV_F2;
          end
        end
        ST_LV_D1: if (div_rsp.done) state <= ST_LV_M1;
        ST_LV_M1: begin
          if (mul_valid) begin
            t1    <= mul_prod;
            state <= ST_LV_F2;
          end
        end
        ST_LV_F2: begin
          if (bb != '0) begin
            state <= ST_LV_D2;
          end else begin
            t2    <= '0;
            state <= ST_LV_W;
          end
        end
        ST_LV_D2: if (div_rsp.done) state <= ST_LV_M2;
        ST_LV_M2: begin
          if (mul_valid) begin
            t2    <= mul_prod;
            state <= ST_LV_W;
          end
        end
        ST_LV_W: begin
          if (lv_last) begin
            idx <= '0;
            if (lvl == PW'(DEGREE)) begin
              state <= ST_SUM_R;
            end else begin
              lvl   <= lvl + PW'(1);
              state <= ST_LV_R0;
            end
          end else begin
            idx   <= idx + KI'(1);
            state <= ST_LV_R0;
          end
        end
        ST_SUM_R: state <= ST_SUM_M;
        ST_SUM_M: state <= ST_SUM_W;
        ST_SUM_W: begin
          if (mul_valid) begin
            acc <= acc + 40'(mul_prod);
            if (sum_last) begin
              state <= ST_FINISH;
            end else begin
              idx   <= idx + KI'(1);
              state <= ST_SUM_R;
            end
          end
        end
        ST_FINISH: begin
          result.curve_value     <= (clamp_negative && acc_sat[31]) ? '0 : acc_sat;
          result.outside_support <= outside;
          result_strobe          <= 1'b1;
          state                  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/bce_checker.sv @@
// Port-level checker for the spline evaluator and its bind to the top level.
`include "bspline_curve_evaluate_defines.svh"

module bce_port_checker import bce_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input in_item_t request,
  input logic     result_strobe,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  `BCE_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe)
  `BCE_ASSERT_IMPL(a_strobe_after_busy, result_strobe, $past(busy))
  `BCE_ASSERT_NEXT(a_eval_goes_busy, start && !busy && request.action == ACT_EVAL, busy)
  `BCE_ASSERT_NEXT(a_load_stays_idle, start && !busy && request.action != ACT_EVAL, !busy && !result_strobe)
  `BCE_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind bspline_curve_evaluate bce_port_checker u_bce_checker (.*);

@@ verif/bce_checker.sv @@
// Spline evaluator checker: predicts each evaluation and compares the strobed results.
module bce_checker import bce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  request,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic      result_strobe,
  input  out_item_t result,
  output int        fail_count,
  output int        pending
);

  localparam int NKNOT = 32;
  localparam int DEG = 3;
  localparam int NCOEF = NKNOT - 1 - DEG;

  logic [31:0]        knot_tab [NKNOT];
  logic signed [31:0] coef_tab [NKNOT];
  logic [5:0]         knots_cfg;
  logic               clamp_cfg;
  out_item_t          expected_q [$];

  assign pending = expected_q.size();

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint span_ratio(longint num, longint den);
    if (den == 0) return 0;
    return sat_s32((num * (64'sd1 <<< 30)) / den);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / (64'sd1 <<< 30);
  endfunction

  function automatic longint kv(int i);
    return longint'({32'b0, knot_tab[i]});
  endfunction

  function automatic out_item_t predict_curve(logic [31:0] x);
    longint    bas [NKNOT];
    longint    acc, xi, f1, f2;
    int        n, nspl;
    out_item_t r;
    n = (knots_cfg > NKNOT) ? NKNOT : int'(knots_cfg);
    xi = longint'({32'b0, x});
    acc = 0;
    if (n < 2) r.outside_support = 1'b1;
    else r.outside_support = (x < knot_tab[0] || x >= knot_tab[n-1]);
    nspl = n - 1 - DEG;
    if (nspl > 0) begin
      for (int i = 0; i < n - 1; i++)
        bas[i] = (x >= knot_tab[i] && x < knot_tab[i+1]) ? (64'sd1 <<< 30) : 0;
      for (int p = 1; p <= DEG; p++) begin
        for (int i = 0; i < n - 1 - p; i++) begin
          f1 = span_ratio(xi - kv(i), kv(i+p) - kv(i));
          f2 = span_ratio(kv(i+p+1) - xi, kv(i+p+1) - kv(i+1));
          bas[i] = sat_s32(q30_mul(f1, bas[i]) + q30_mul(f2, bas[i+1]));
        end
      end
      for (int i = 0; i < nspl; i++)
        acc += q30_mul(longint'(coef_tab[i]), bas[i]);
    end
    acc = sat_s32(acc);
    if (clamp_cfg && acc < 0) acc = 0;
    r.curve_value = acc[31:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < NKNOT; i++) begin
        knot_tab[i] = '0;
        coef_tab[i] = '0;
      end
      knots_cfg = KNOTS_RESET;
      clamp_cfg = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KNOTS_IN_USE) knots_cfg = cfg_data;
        else if (cfg_index == REG_CLAMP_NEGATIVE) clamp_cfg = cfg_data[0];
      end
      if (result_strobe) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, value", result.curve_value, 0);
        end else begin
          want = expected_q.pop_front();
          if (result.curve_value !== want.curve_value)
            report("curve_value", result.curve_value, want.curve_value);
          if (result.outside_support !== want.outside_support)
            report("outside_support", result.outside_support, want.outside_support);
        end
      end
      if (start && !busy) begin
        case (request.action)
          ACT_LOAD_KNOT: knot_tab[request.slot] = request.knot_value;
          ACT_LOAD_COEF: if (request.slot < NCOEF) coef_tab[request.slot] = request.coefficient;
          ACT_EVAL:      expected_q.push_back(predict_curve(request.sample_x));
          default: ;
        endcase
      end
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the spline evaluator: clock, reset, stimulus and verdict.
module tb;
  import bce_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  request = '0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic      result_strobe;
  out_item_t result;
  int        fail_count;
  int        pending;
  int        sent = 0;

  logic [31:0] knot_img [32];
  int          n_live;

  always #2 clk = ~clk;

  bspline_curve_evaluate dut (.*);

  bce_checker checker_i (.*);

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

  task automatic idle_gap();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Holds the request until the block takes it; start stays high for a follow-on request unless an idle gap drops it.
  task automatic send(in_item_t it);
    logic took;
    start <= 1'b1;
    request <= it;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    sent++;
    idle_gap();
  endtask

  task automatic load_knot(int s, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.action = ACT_LOAD_KNOT;
    it.slot = 5'(s);
    it.knot_value = v;
    it.coefficient = $urandom;
    it.sample_x = $urandom;
    knot_img[s] = v;
    send(it);
  endtask

  task automatic load_coef(int s, logic [31:0] c);
    in_item_t it;
    it = '0;
    it.action = ACT_LOAD_COEF;
    it.slot = 5'(s);
    it.coefficient = c;
    it.knot_value = $urandom;
    it.sample_x = $urandom;
    send(it);
  endtask

  task automatic eval_at(logic [31:0] x, logic [1:0] act = ACT_EVAL);
    in_item_t it;
    it.action = act;
    it.slot = 5'($urandom);
    it.knot_value = $urandom;
    it.coefficient = $urandom;
    it.sample_x = x;
    send(it);
  endtask

  // Waits for every expected result, then for a block that may still be busy.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [5:0] v);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic set_mode(logic [5:0] n, logic cl);
    drain();
    write_reg(REG_KNOTS_IN_USE, n);
    write_reg(REG_CLAMP_NEGATIVE, {5'($urandom_range(0, 31)), cl});
    cfg_valid <= 1'b0;
    n_live = (n > 32) ? 32 : n;
  endtask

  function automatic logic [31:0] pick_x();
    int r, lo, hi;
    logic [31:0] a, b;
    r = $urandom_range(0, 99);
    lo = 0;
    hi = (n_live > 1) ? n_live - 1 : 0;
    a = knot_img[lo];
    b = knot_img[hi];
    if (r < 10) return $urandom;
    if (r < 25) return knot_img[$urandom_range(lo, hi)];
    if (r < 30) return a - $urandom_range(1, 1000);
    if (r < 35) return b + $urandom_range(0, 1000);
    if (b > a) return a + ($urandom % (b - a));
    return a;
  endfunction

  // Rewrites the live knots; kind 0 random rising steps, 1 with repeats, 2 full range sorted, 3 unsorted.
  task automatic load_knot_set(int kind);
    logic [31:0] q [$];
    logic [31:0] v;
    v = $urandom_range(0, 32'h0004_0000);
    for (int i = 0; i < 32; i++) begin
      case (kind)
        0: v += $urandom_range(1, 32'h0003_0000);
        1: v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32'h0002_0000);
        default: v = $urandom;
      endcase
      q.push_back(v);
    end
    if (kind == 2) q.sort();
    for (int i = 0; i < n_live; i++) load_knot(i, q[i]);
  endtask

  task automatic load_coef_set();
    int cnt;
    cnt = $urandom_range(4, 28);
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 5))
        0: load_coef($urandom_range(0, 27), $urandom);
        1: load_coef($urandom_range(28, 31), $urandom);
        default: load_coef($urandom_range(0, 27), $signed($urandom_range(0, 32'h0010_0000))
                           - 32'sh0008_0000);
      endcase
    end
  endtask

  initial begin
    logic [5:0] nsel;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill both tables so no evaluation reads an unwritten entry.
    for (int i = 0; i < 32; i++) load_knot(i, i * 32'h0001_0000);
    for (int i = 0; i < 28; i++) load_coef(i, (i % 2) ? 32'sh0001_0000 : -32'sh0002_0000);
    n_live = 8;

    // Directed: edges of the support, extremes, ignored requests, zero spans, clamping.
    eval_at(32'h0000_0000);
    eval_at(32'h0002_8000);
    eval_at(32'h0007_0000);
    eval_at(32'hFFFF_FFFF);
    eval_at(32'h0003_0000, ACT_UNUSED);
    load_coef(29, 32'h7FFF_FFFF);
    load_coef(0, 32'h7FFF_FFFF);
    load_coef(1, 32'h7FFF_FFFF);
    load_coef(2, 32'h8000_0000);
    eval_at(32'h0003_0000);
    eval_at(32'h0003_8000);
    load_knot(3, 32'h0002_0000);
    eval_at(32'h0002_0000);
    set_mode(6'd8, 1'b1);
    eval_at(32'h0004_8000);
    for (int m = 0; m < 7; m++) begin
      case (m)
        0: nsel = 6'd0;
        1: nsel = 6'd1;
        2: nsel = 6'd4;
        3: nsel = 6'd5;
        4: nsel = 6'd32;
        5: nsel = 6'd33;
        default: nsel = 6'd63;
      endcase
      set_mode(nsel, m[0]);
      eval_at(32'h0003_4000);
    end

    while (sent < 600) begin
      case ($urandom_range(0, 7))
        0: nsel = $urandom_range(0, 63);
        1: nsel = 6'd5;
        2: nsel = 6'd32;
        default: nsel = $urandom_range(5, 12);
      endcase
      set_mode(nsel, $urandom_range(0, 1));
      load_knot_set($urandom_range(0, 3));
      load_coef_set();
      repeat ($urandom_range(6, 20)) begin
        if ($urandom_range(0, 19) == 0) eval_at($urandom, ACT_UNUSED);
        else eval_at(pick_x());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/bce_pkg.sv
design/bce_divider.sv
design/bce_product.sv
design/bspline_curve_evaluate.sv
design/bce_checker.sv
verif/bce_checker.sv
verif/tb.sv
